FILE: rtl/core/rail_fence_cipher_core_defines.svh
// Assertion macros shared by the rail fence cipher core.
`ifndef RAIL_FENCE_CIPHER_CORE_DEFINES_SVH
`define RAIL_FENCE_CIPHER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define RFC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define RFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define RFC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define RFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/rfc_pkg.sv
`default_nettype none

package rfc_pkg;

    localparam int MAX_LEN   = 64;
    localparam int MAX_RAILS = 16;

    localparam int DATA_W  = 8;
    localparam int RAILS_W = 5;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int ROW_W   = $clog2(MAX_RAILS);
    localparam int STEP_W  = $clog2(2 * MAX_RAILS - 1);
    localparam int POS_W   = $clog2(MAX_LEN + 2 * MAX_RAILS);

    localparam logic [RAILS_W-1:0] RAILS_MIN   = RAILS_W'(2);
    localparam logic [RAILS_W-1:0] RAILS_MAX   = RAILS_W'(MAX_RAILS);
    localparam logic [RAILS_W-1:0] RAILS_RESET = RAILS_W'(2);

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_RAILS  = 1'b0,
        REG_DECRYPT = 1'b1
    } rfc_reg_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PERMUTE,
        ST_DRAIN,
        ST_EMIT
    } rfc_state_t;

    typedef struct packed {
        logic accept_en;
        logic walk_init;
        logic walk_step;
        logic emit_en;
    } rfc_cmd_t;

    typedef struct packed {
        logic last_xfer;
        logic walk_last;
        logic emit_last;
    } rfc_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/rfc_ctrl.sv
`default_nettype none

module rfc_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  rfc_pkg::rfc_status_t status,
    output rfc_pkg::rfc_cmd_t    cmd
);
    import rfc_pkg::*;

    rfc_state_t state_reg;
    rfc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (status.last_xfer)
                begin
                    state_next = ST_PERMUTE;
                end
            end
            ST_PERMUTE:
            begin
                if (status.walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.emit_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_LOAD:
            begin
                cmd.accept_en = 1'b1;
                cmd.walk_init = 1'b1;
            end
            ST_PERMUTE:
            begin
                cmd.walk_step = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd = '0;
            end
            ST_EMIT:
            begin
                cmd.emit_en = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/rfc_datapath.sv
`default_nettype none

module rfc_datapath (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire  [0:0]                           cfg_addr,
    input  wire  [rfc_pkg::RAILS_W-1:0]          cfg_wdata,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [rfc_pkg::DATA_W-1:0]           s_axis_tdata,
    input  wire                                  s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [rfc_pkg::DATA_W-1:0]           m_axis_tdata,
    output logic                                 m_axis_tlast,
    output logic                                 m_axis_tuser,
    input  rfc_pkg::rfc_cmd_t                    cmd,
    output rfc_pkg::rfc_status_t                 status
);
    import rfc_pkg::*;

    logic [DATA_W-1:0] store_mem [MAX_LEN];
    logic [DATA_W-1:0] res_mem   [MAX_LEN];

    logic [RAILS_W-1:0] rails_reg;
    logic               decrypt_reg;
    logic [CNT_W-1:0]   count_reg,   count_next;
    logic               ovf_reg,     ovf_next;
    logic [ROW_W-1:0]   row_reg,     row_next;
    logic [POS_W-1:0]   pos_reg,     pos_next;
    logic               par_reg,     par_next;
    logic [ADDR_W-1:0]  k_reg,       k_next;
    logic [ADDR_W-1:0]  ecnt_reg,    ecnt_next;
    logic               wv_reg;
    logic [ADDR_W-1:0]  wa_reg;
    logic [DATA_W-1:0]  store_q_reg;
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_byte_reg;
    logic               out_last_reg;
    logic               out_ovf_reg;

    logic               accept;
    logic               store_full;
    logic [RAILS_W-1:0] r_eff;
    logic               edge_row;
    logic [STEP_W-1:0]  step;
    logic [POS_W-1:0]   pos_sum;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [CNT_W-1:0]   last_idx;
    logic               emit_issue;
    logic               emit_last;

    assign s_axis_tready = cmd.accept_en;
    assign accept        = s_axis_tvalid && cmd.accept_en;
    assign store_full    = (count_reg == CNT_W'(MAX_LEN));
    assign last_idx      = CNT_W'(count_reg - 1'b1);

    // Clamp the rail count into range
    always_comb
    begin
        priority if (rails_reg < RAILS_MIN)
        begin
            r_eff = RAILS_MIN;
        end
        else if (rails_reg > RAILS_MAX)
        begin
            r_eff = RAILS_MAX;
        end
        else
        begin
            r_eff = rails_reg;
        end
    end

    // Zigzag step for the current position on the current rail
    always_comb
    begin
        edge_row = (row_reg == '0) || (RAILS_W'(row_reg) == RAILS_W'(r_eff - 1'b1));
        priority if (edge_row)
        begin
            step = STEP_W'({r_eff, 1'b0} - (RAILS_W + 1)'(2));
        end
        else if (!par_reg)
        begin
            step = STEP_W'({RAILS_W'(r_eff - 1'b1 - RAILS_W'(row_reg)), 1'b0});
        end
        else
        begin
            step = STEP_W'({RAILS_W'(row_reg), 1'b0});
        end
    end

    assign pos_sum = pos_reg + POS_W'(step);
    assign rd_addr = decrypt_reg ? k_reg : pos_reg[ADDR_W-1:0];
    assign wr_addr = decrypt_reg ? pos_reg[ADDR_W-1:0] : k_reg;

    assign emit_issue = cmd.emit_en && (!out_valid_reg || m_axis_tready);
    assign emit_last  = emit_issue && (CNT_W'(ecnt_reg) == last_idx);

    assign status.last_xfer = accept && s_axis_tlast;
    assign status.walk_last = cmd.walk_step && (CNT_W'(k_reg) == last_idx);
    assign status.emit_last = emit_last;

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (store_full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = CNT_W'(count_reg + 1'b1);
            end
        end
        else if (emit_last)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    // Walk generator: advance along the rail, or drop to the next rail
    always_comb
    begin
        row_next  = row_reg;
        pos_next  = pos_reg;
        par_next  = par_reg;
        k_next    = k_reg;
        ecnt_next = ecnt_reg;
        if (cmd.walk_init)
        begin
            row_next  = '0;
            pos_next  = '0;
            par_next  = 1'b0;
            k_next    = '0;
            ecnt_next = '0;
        end
        else if (cmd.walk_step)
        begin
            k_next = ADDR_W'(k_reg + 1'b1);
            if (pos_sum >= POS_W'(count_reg))
            begin
                row_next = ROW_W'(row_reg + 1'b1);
                pos_next = POS_W'(POS_W'(row_reg) + 1'b1);
                par_next = 1'b0;
            end
            else
            begin
                pos_next = pos_sum;
                par_next = ~par_reg;
            end
        end
        else if (emit_issue)
        begin
            ecnt_next = ADDR_W'(ecnt_reg + 1'b1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_issue)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rails_reg     <= RAILS_RESET;
            decrypt_reg   <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            row_reg       <= '0;
            pos_reg       <= '0;
            par_reg       <= 1'b0;
            k_reg         <= '0;
            ecnt_reg      <= '0;
            wv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (rfc_reg_t'(cfg_addr))
                    REG_RAILS:   rails_reg   <= cfg_wdata;
                    REG_DECRYPT: decrypt_reg <= cfg_wdata[0];
                    default:     rails_reg   <= rails_reg;
                endcase
            end
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            row_reg       <= row_next;
            pos_reg       <= pos_next;
            par_reg       <= par_next;
            k_reg         <= k_next;
            ecnt_reg      <= ecnt_next;
            wv_reg        <= cmd.walk_step;
            out_valid_reg <= out_valid_next;
        end
    end

    // Message buffer: write on input transfer, read during the walk
    always_ff @(posedge clk)
    begin
        if (accept && !store_full)
        begin
            store_mem[count_reg[ADDR_W-1:0]] <= s_axis_tdata;
        end
        if (cmd.walk_step)
        begin
            store_q_reg <= store_mem[rd_addr];
            wa_reg      <= wr_addr;
        end
    end

    // Permuted buffer: written the cycle after the walk, read for output
    always_ff @(posedge clk)
    begin
        if (wv_reg)
        begin
            res_mem[wa_reg] <= store_q_reg;
        end
        if (emit_issue)
        begin
            out_byte_reg <= res_mem[ecnt_reg];
            out_last_reg <= emit_last;
            out_ovf_reg  <= ovf_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rail_fence_cipher_core.sv
// After the tlast input transfer the walk reads each message byte in turn, the last
//   write-back drains, and then the first output byte is read out.
// Messages go one at a time: load, permute and emit run in turn over two 64-byte
//   buffers with a single read port each; input resumes once the last byte is issued.
// Reset: control state and counters clear, rails returns to 2 and mode to encrypt;
//   buffer contents are left as they are.
`default_nettype none
`include "rail_fence_cipher_core_defines.svh"

module rail_fence_cipher_core (
    input  wire                          clk,
    input  wire                          rst_n,
    // Configuration write port: index 0 rails, index 1 decrypt_mode
    input  wire                          cfg_we,
    input  wire  [0:0]                   cfg_addr,
    input  wire  [rfc_pkg::RAILS_W-1:0]  cfg_wdata,
    // Message input
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [rfc_pkg::DATA_W-1:0]   s_axis_tdata,   // [7:0] data_byte
    input  wire                          s_axis_tlast,   // last_in
    // Permuted output
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [rfc_pkg::DATA_W-1:0]   m_axis_tdata,   // [7:0] out_byte
    output logic                         m_axis_tlast,   // out_last
    output logic                         m_axis_tuser    // [0] overflow
);
    import rfc_pkg::*;

    rfc_cmd_t    cmd;
    rfc_status_t status;

    // Sequencer: load, walk the zigzag, drain the write-back, emit
    rfc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // Buffers, walk generator, registers and the output stage
    rfc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cmd           (cmd),
        .status        (status)
    );

    // Never take input while the walk is reading the buffer
    `RFC_ASSERT_IMPLIES(a_no_load_in_walk, clk, rst_n, cmd.walk_step, !s_axis_tready)
    // In the cycle after the final walk step, neither walk nor emit: the write-back drains
    `RFC_ASSERT_NEXT(a_drain_after_walk, clk, rst_n, status.walk_last, !cmd.walk_step && !cmd.emit_en)
    // Once the final byte is issued, return to loading
    `RFC_ASSERT_NEXT(a_load_after_emit, clk, rst_n, status.emit_last, cmd.accept_en)

endmodule

`default_nettype wire

FILE: dv/tb_rail_fence_cipher_core.sv
`timescale 1ns / 100ps

// Stream bench for the rail fence cipher core.
// Messages go in as byte transfers closed by tlast. The scoreboard keeps its own copy of
// the message buffer and of the two registers, and it builds the zigzag order when a
// message closes. The output stream is then checked byte for byte against that order,
// with tlast and the overflow flag.
module tb_rail_fence_cipher_core;

    import rfc_pkg::*;

    // Longest message plus its emit pass, with some margin; used as the quiet
    // time before a register write and before the final verdict.
    localparam int SETTLE_CYCLES = 2 * MAX_LEN + 16;
    // Long receiver hold-off, enough to stall the output of an overlong message.
    localparam int HOLD_CYCLES   = 400;

    // Scoreboard: mirrors the message buffer and the registers, and queues the
    // permuted bytes that each closed message must produce.
    class rail_fence_scoreboard;
        typedef struct packed {
            logic [DATA_W-1:0] value;
            logic              last;
            logic              cut;
        } out_beat_t;

        logic [DATA_W-1:0]  held_bytes[$];
        bit                 dropped;
        logic [RAILS_W-1:0] rails_key;
        bit                 decrypt;
        out_beat_t          beats_due[$];
        int                 errors;
        int                 bytes_sent;
        int                 messages;
        int                 cut_messages;
        int                 beats_seen;

        function new();
            rails_key    = RAILS_RESET;
            decrypt      = 1'b0;
            dropped      = 1'b0;
            errors       = 0;
            bytes_sent   = 0;
            messages     = 0;
            cut_messages = 0;
            beats_seen   = 0;
        endfunction

        function void write_reg(rfc_reg_t idx, logic [RAILS_W-1:0] value);
            if (idx == REG_RAILS)
                rails_key = value;
            else
                decrypt = value[0];
        endfunction

        function void note_byte(logic [DATA_W-1:0] value, bit last);
            int                order[$];
            logic [DATA_W-1:0] permuted[MAX_LEN];
            int                n;
            int                r;
            int                row;
            int                pos;
            int                taken;
            int                stride;
            out_beat_t         beat;
            bytes_sent++;
            // Keep the first MAX_LEN bytes; anything later is lost, tlast byte included.
            if (held_bytes.size() < MAX_LEN)
                held_bytes.push_back(value);
            else
                dropped = 1'b1;
            if (!last)
                return;
            n = held_bytes.size();
            r = int'(rails_key);
            if (r < 2)
                r = 2;
            if (r > MAX_RAILS)
                r = MAX_RAILS;
            // Walk each rail; inner rails alternate the down and up strides.
            for (row = 0; row < r; row++)
            begin
                pos   = row;
                taken = 0;
                while (pos < n && order.size() < n)
                begin
                    order.push_back(pos);
                    taken++;
                    if (row == 0 || row == r - 1)
                        stride = 2 * r - 2;
                    else if (taken % 2 == 0)
                        stride = 2 * row;
                    else
                        stride = 2 * (r - 1 - row);
                    pos += stride;
                end
            end
            for (int k = 0; k < n; k++)
            begin
                if (decrypt)
                    permuted[order[k]] = held_bytes[k];
                else
                    permuted[k] = held_bytes[order[k]];
            end
            for (int k = 0; k < n; k++)
            begin
                beat.value = permuted[k];
                beat.last  = (k == n - 1);
                beat.cut   = dropped;
                beats_due.push_back(beat);
            end
            messages++;
            if (dropped)
                cut_messages++;
            held_bytes.delete();
            dropped = 1'b0;
        endfunction

        function void check_beat(logic [DATA_W-1:0] value, logic last, logic cut);
            out_beat_t want;
            beats_seen++;
            if (beats_due.size() == 0)
            begin
                errors++;
                $error("unexpected output transfer: out_byte %02h", value);
                return;
            end
            want = beats_due.pop_front();
            if (value !== want.value)
            begin
                errors++;
                $error("out_byte: expected %02h, got %02h", want.value, value);
            end
            if (last !== want.last)
            begin
                errors++;
                $error("out_last: expected %0b, got %0b", want.last, last);
            end
            if (cut !== want.cut)
            begin
                errors++;
                $error("overflow: expected %0b, got %0b", want.cut, cut);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [0:0]          cfg_addr;
    logic [RAILS_W-1:0]  cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata;
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [DATA_W-1:0]   m_axis_tdata;
    logic                m_axis_tlast;
    logic                m_axis_tuser;

    rail_fence_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    // Fixed directed message bytes; together they toggle every data bit.
    logic [DATA_W-1:0] fixed_bytes[8] =
        '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7E, 8'hC3};

    rail_fence_cipher_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: decide tready at each falling edge. A pending hold-off wins over
    // random stalls and is counted down here, independent of the sender.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready = 1'b0;
                hold_left--;
            end
            else
                m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Output monitor: sample at the rising edge, check every accepted transfer.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
    end

    // Safety net against a hung handshake.
    initial
    begin
        #4_000_000;
        $display("FAIL rail_fence_cipher_core");
        $finish;
    end

    // Write one register at the next rising edge; call at a falling edge.
    task automatic write_reg(rfc_reg_t idx, logic [RAILS_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = value;
        sb.write_reg(idx, value);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Offer one byte and hold it until the core takes it. Leave tvalid high
    // afterwards, so back-to-back bytes keep it asserted without a dip.
    task automatic send_byte(logic [DATA_W-1:0] value, bit last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = value;
        s_axis_tlast  = last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_byte(value, last);
        @(negedge clk);
    endtask

    // Send len bytes of the fixed pattern, starting at entry first; close with
    // tlast only when asked, so a message can be left open across a pause.
    task automatic send_fixed(int first, int len, bit close);
        for (int i = 0; i < len; i++)
            send_byte(fixed_bytes[(first + i) % 8], close && (i == len - 1));
    endtask

    task automatic send_random_message(int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)), i == len - 1);
    endtask

    // Mostly short messages; now and then a long one, rarely one past the buffer.
    function automatic int pick_length();
        int roll;
        roll = $urandom_range(99);
        if (roll < 85)
            return $urandom_range(12, 1);
        else if (roll < 97)
            return $urandom_range(MAX_LEN, 13);
        else
            return $urandom_range(MAX_LEN + 4, MAX_LEN + 1);
    endfunction

    // Stop offering and wait until every awaited byte has been checked.
    task automatic drain_outputs();
        s_axis_tvalid = 1'b0;
        while (sb.beats_due.size() != 0)
            @(negedge clk);
    endtask

    // Drain, then give an open or just-closed message time to clear the core.
    task automatic settle();
        drain_outputs();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_idling(int kind);
        case (kind)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 81;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 81;
            end
            default:
            begin
                send_idle_pct  = 16;
                recv_stall_pct = 16;
            end
        endcase
    endtask

    // One random phase: new register settings, one idling style, then random
    // messages until the byte budget is used up. Sometimes pause for a drain.
    task automatic run_phase(logic [RAILS_W-1:0] rails_val, bit decrypt_val, int kind,
                             int budget);
        int start;
        settle();
        write_reg(REG_RAILS, rails_val);
        write_reg(REG_DECRYPT, RAILS_W'(decrypt_val));
        set_idling(kind);
        start = sb.bytes_sent;
        while (sb.bytes_sent - start < budget)
        begin
            send_random_message(pick_length());
            if ($urandom_range(7) == 0)
                drain_outputs();
        end
        drain_outputs();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = REG_RAILS;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, no idling.
        set_idling(0);
        write_reg(REG_RAILS, RAILS_W'(3));
        write_reg(REG_DECRYPT, RAILS_W'(0));
        send_byte(8'hFF, 1'b1);            // one-byte message
        send_fixed(0, 2, 1'b1);            // all-zero and all-one bytes
        send_fixed(2, 5, 1'b1);            // inner rail alternates its strides

        // Registers change while a message is open: the values at tlast rule.
        send_fixed(3, 3, 1'b0);
        settle();
        write_reg(REG_RAILS, RAILS_W'(4));
        write_reg(REG_DECRYPT, RAILS_W'(1));
        send_fixed(6, 2, 1'b1);

        // Rails below the minimum act as two rails.
        settle();
        write_reg(REG_RAILS, RAILS_W'(0));
        write_reg(REG_DECRYPT, RAILS_W'(0));
        send_fixed(1, 4, 1'b1);

        // Rails above the maximum act as sixteen; the message is shorter, so it
        // passes through unchanged.
        settle();
        write_reg(REG_RAILS, RAILS_W'(31));
        write_reg(REG_DECRYPT, RAILS_W'(1));
        send_fixed(2, 6, 1'b1);

        // Random phases through the idling styles and the key extremes.
        run_phase(RAILS_W'(2),  1'b0, 0, 8);
        run_phase(RAILS_W'(16), 1'b1, 1, 8);
        run_phase(RAILS_W'(2),  1'b1, 2, 8);
        run_phase(RAILS_W'(16), 1'b0, 3, 8);
        run_phase(RAILS_W'(7),  1'b1, 0, 8);
        run_phase(RAILS_W'($urandom_range(31)), 1'($urandom_range(1)), 1, 8);

        // Back-pressure: hold the receiver off while an overlong message overflows
        // the buffer, so the output stalls with the overflow flag set.
        settle();
        write_reg(REG_RAILS, RAILS_W'(5));
        write_reg(REG_DECRYPT, RAILS_W'(0));
        set_idling(0);
        hold_left = HOLD_CYCLES;
        send_random_message(MAX_LEN + 1);
        drain_outputs();
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (sb.beats_due.size() != 0)
        begin
            sb.errors++;
            $error("%0d output bytes never arrived", sb.beats_due.size());
        end
        $display("Covered %0d input bytes in %0d messages, %0d cut short at the buffer size;",
                 sb.bytes_sent, sb.messages, sb.cut_messages);
        $display("checked %0d output bytes in both modes across rails from 0 to 31.",
                 sb.beats_seen);
        if (sb.errors == 0)
            $display("PASS rail_fence_cipher_core");
        else
            $display("FAIL rail_fence_cipher_core");
        $finish;
    end

endmodule
